### rtl/core/abf_pkg.sv
package abf_pkg;

    // Image geometry
    localparam int IMAGE_SIDE  = 32;
    localparam int STORE_DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Pixel channel width and blend constants
    localparam int CH_W               = 8;
    localparam int PIX_W              = 4 * CH_W;
    localparam logic [CH_W-1:0] ALPHA_MAX  = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_ZERO = 8'h00;
    localparam logic [23:0] ROUND_HALF = 24'd127;

    // Dividend of the per-channel divide: sc*sa + mixed + oa/2 stays below 2^17
    localparam int DVD_W = 17;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // Rounded-down division by 255 via reciprocal (32896 / 2^23) and one correction.
    // Exact for v below 255 * 2^16, which covers every value the blend produces.
    function automatic logic [15:0] div255(input logic [23:0] v);
        logic [39:0] prod;
        logic [16:0] q0;
        logic [24:0] qm;
        logic [24:0] rem;
        logic [16:0] q;
        prod = ({16'b0, v} << 15) + ({16'b0, v} << 7);
        q0   = prod[39:23];
        qm   = {q0, 8'b0} - {8'b0, q0};
        rem  = {1'b0, v} - qm;
        q    = (rem >= 25'd255) ? q0 + 17'd1 : q0;
        return q[15:0];
    endfunction

endpackage

### rtl/core/abf_req_if.sv
interface abf_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        src_red;
    logic [7:0]        src_green;
    logic [7:0]        src_blue;
    logic [7:0]        src_alpha;

    modport source (
        output valid, req_type, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
        input  ready
    );

    modport sink (
        input  valid, req_type, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

### rtl/core/abf_rsp_if.sv
interface abf_rsp_if;
    logic       valid;
    logic       ready;
    logic       in_range;
    logic [7:0] pix_alpha;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;

    modport source (
        output valid, in_range, pix_alpha, pix_red, pix_green, pix_blue,
        input  ready
    );

    modport sink (
        input  valid, in_range, pix_alpha, pix_red, pix_green, pix_blue,
        output ready
    );
endinterface

### rtl/core/abf_div.sv
// Restoring divider, one quotient bit per cycle.
module abf_div
    import abf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CH_W-1:0]  divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CH_W-1:0]  rem_reg, rem_next;
    logic [CH_W-1:0]  dsr_reg, dsr_next;
    logic [CH_W:0]    trial;
    logic             fits;

    // One shift-and-subtract step
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? CH_W'(trial - {1'b0, dsr_reg}) : trial[CH_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### rtl/core/alpha_blend_framebuffer_top.sv
// Square ARGB8888 framebuffer (IMAGE_SIDE x IMAGE_SIDE, row-major) with a source-over
// blend port. After reset the block clears all STORE_DEPTH pixels (1024 at the default
// size), one pixel per cycle, with req.ready low. One request is worked at a time
// through a synchronous pixel memory with one write port and one registered read
// port: read, modify, write back. A read, zero source alpha or a plain replace passes
// ST_READ and ST_DONE, an off-image request only ST_DONE; a true blend also passes
// ST_MUL, ST_MIX, ST_PRE and ST_DIV, where three parallel restoring dividers (17 steps,
// one quotient bit per cycle) divide each color channel by the output alpha. A finished
// result sits in an output register, so the block accepts again as soon as it is loaded.
module alpha_blend_framebuffer_top
    import abf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    abf_req_if.sink      req,
    abf_rsp_if.source    rsp
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_MIX   = 8'b0001_0000,
        ST_PRE   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // Control
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Request and working values
    logic              req_type_reg, req_type_next;
    logic              in_range_reg, in_range_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CH_W-1:0]   sa_reg, sa_next;
    logic [CH_W-1:0]   src_reg [3];
    logic [CH_W-1:0]   src_next [3];
    logic              wr_pend_reg, wr_pend_next;
    logic [PIX_W-1:0]  res_pix_reg, res_pix_next;
    logic [15:0]       da_inv_reg, da_inv_next;
    logic [15:0]       scsa_reg [3];
    logic [15:0]       scsa_next [3];
    logic [15:0]       dcda_reg [3];
    logic [15:0]       dcda_next [3];
    logic [23:0]       mix_reg [3];
    logic [23:0]       mix_next [3];
    logic [CH_W-1:0]   oa_reg, oa_next;

    // Output register
    logic              o_in_range_reg, o_in_range_next;
    logic [PIX_W-1:0]  o_pix_reg, o_pix_next;

    // Memory ports
    logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [PIX_W-1:0]  wr_data;

    // Dividers
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd [3];
    logic [DVD_W-1:0]  div_quo [3];
    logic [2:0]        div_done;

    // Helpers
    logic              req_in_range;
    logic [ADDR_W-1:0] req_addr;
    logic [CH_W-1:0]   da, inv;
    logic [8:0]        oa_sum;
    logic [CH_W-1:0]   q_sat [3];
    logic              out_free, out_load;

    // Coordinate check: negative values read as large unsigned numbers
    assign req_in_range = ($unsigned(req.pos_x) < 8'(IMAGE_SIDE))
                       && ($unsigned(req.pos_y) < 8'(IMAGE_SIDE));
    assign req_addr = ADDR_W'(ADDR_W'($unsigned(req.pos_y)) * ADDR_W'(IMAGE_SIDE)
                              + ADDR_W'($unsigned(req.pos_x)));

    assign da       = rd_data_reg[31:24];
    assign inv      = ALPHA_MAX - sa_reg;
    assign oa_sum   = {1'b0, sa_reg} + 9'(div255(24'(da_inv_reg) + ROUND_HALF));
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_dvd[i] = 17'(scsa_reg[i]) + 17'(div255(mix_reg[i] + ROUND_HALF))
                       + 17'(oa_reg >> 1);
            q_sat[i]   = (div_quo[i] > 17'(ALPHA_MAX)) ? ALPHA_MAX : div_quo[i][CH_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        req_type_next   = req_type_reg;
        in_range_next   = in_range_reg;
        addr_next       = addr_reg;
        sa_next         = sa_reg;
        src_next        = src_reg;
        wr_pend_next    = wr_pend_reg;
        res_pix_next    = res_pix_reg;
        da_inv_next     = da_inv_reg;
        scsa_next       = scsa_reg;
        dcda_next       = dcda_reg;
        mix_next        = mix_reg;
        oa_next         = oa_reg;
        rd_en           = 1'b0;
        rd_addr         = req_addr;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = res_pix_reg;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (req.valid) begin
                    req_type_next = req.req_type;
                    in_range_next = req_in_range;
                    addr_next     = req_addr;
                    sa_next       = req.src_alpha;
                    src_next[0]   = req.src_red;
                    src_next[1]   = req.src_green;
                    src_next[2]   = req.src_blue;
                    wr_pend_next  = 1'b0;
                    res_pix_next  = '0;
                    rd_en         = 1'b1;
                    state_next    = req_in_range ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                if (req_type_reg || sa_reg == ALPHA_ZERO) begin
                    res_pix_next = rd_data_reg;
                    state_next   = ST_DONE;
                end else if (sa_reg == ALPHA_MAX || da == ALPHA_ZERO) begin
                    res_pix_next = {sa_reg, src_reg[0], src_reg[1], src_reg[2]};
                    wr_pend_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                da_inv_next = 16'(da) * 16'(inv);
                for (int i = 0; i < 3; i++) begin
                    scsa_next[i] = 16'(src_reg[i]) * 16'(sa_reg);
                    dcda_next[i] = 16'(rd_data_reg[23-8*i -: 8]) * 16'(da);
                end
                state_next = ST_MIX;
            end
            ST_MIX: begin
                oa_next = (oa_sum > 9'(ALPHA_MAX)) ? ALPHA_MAX : oa_sum[CH_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    mix_next[i] = 24'(dcda_reg[i]) * 24'(inv);
                end
                state_next = ST_PRE;
            end
            ST_PRE: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done[0]) begin
                    res_pix_next = {oa_reg, q_sat[0], q_sat[1], q_sat[2]};
                    wr_pend_next = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    wr_en      = wr_pend_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        o_in_range_next = o_in_range_reg;
        o_pix_next      = o_pix_reg;
        if (out_load) begin
            o_in_range_next = in_range_reg;
            o_pix_next      = res_pix_reg;
        end
        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        req_type_reg   <= req_type_next;
        in_range_reg   <= in_range_next;
        addr_reg       <= addr_next;
        sa_reg         <= sa_next;
        src_reg        <= src_next;
        wr_pend_reg    <= wr_pend_next;
        res_pix_reg    <= res_pix_next;
        da_inv_reg     <= da_inv_next;
        scsa_reg       <= scsa_next;
        dcda_reg       <= dcda_next;
        mix_reg        <= mix_next;
        oa_reg         <= oa_next;
        o_in_range_reg <= o_in_range_next;
        o_pix_reg      <= o_pix_next;
    end

    // Pixel memory: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // One divider lane per color channel
    for (genvar g = 0; g < 3; g++) begin : g_div
        abf_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dvd[g]),
            .divisor  (oa_reg),
            .quotient (div_quo[g]),
            .done     (div_done[g])
        );
    end

    // Ports
    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.in_range  = o_in_range_reg;
    assign rsp.pix_alpha = o_pix_reg[31:24];
    assign rsp.pix_red   = o_pix_reg[23:16];
    assign rsp.pix_green = o_pix_reg[15:8];
    assign rsp.pix_blue  = o_pix_reg[7:0];

    // Divider lanes finish together and only while the sequencer waits for them
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done != 3'b000) |-> (div_done == 3'b111) && (state_reg == ST_DIV))
        else $error("divider done outside of divide wait or lanes out of step");

    // An off-image result carries a zero pixel
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.in_range) |-> (o_pix_reg == '0))
        else $error("off-image result with nonzero pixel");

    // Pixel writes after the clearing pass only target an in-range request
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != ST_CLEAR) |-> (in_range_reg && state_reg == ST_DONE))
        else $error("pixel write without an in-range request");

    // Accepting a request always issues a read or goes straight to the result
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_READ || state_reg == ST_DONE))
        else $error("accepted item not sequenced");

endmodule
